/* design/rcfd_pkg.sv */
// shared types and constants for the remote-control receiver frame decoder
package rcfd_pkg;

  localparam int unsigned FRAME_LENGTH = 18;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CH_W         = 11;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned IN_DATA_W    = 8;
  localparam int unsigned IN_USER_W    = 2;
  localparam int unsigned OUT_DATA_W   = 144;

  localparam logic [COUNT_W-1:0] COUNT_MAX      = 5'd31;
  localparam logic [COUNT_W-1:0] COUNT_FRAME    = 5'(FRAME_LENGTH);
  localparam logic [15:0]        TIMEOUT_RESET  = 16'd1000;
  localparam logic [CH_W-1:0]    LIMIT_RESET    = 11'd700;
  localparam logic [15:0]        ELAPSED_MAX    = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_EOF  = 2'd1,
    OP_TICK = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    LINK_PENDING   = 2'd0,
    LINK_CONNECTED = 2'd1,
    LINK_ERROR     = 2'd2,
    LINK_LOST      = 2'd3
  } link_t;

  typedef enum logic {
    CFG_TIMEOUT = 1'b0,
    CFG_LIMIT   = 1'b1
  } cfg_idx_t;

  // decoded frame, first output field in the lowest bits
  typedef struct packed {
    logic        [15:0]     key_mask;
    logic        [15:0]     mouse_buttons;
    logic signed [15:0]     mouse_z;
    logic signed [15:0]     mouse_y;
    logic signed [15:0]     mouse_x;
    logic        [3:0]      switches;
    logic signed [CH_W-1:0] dial_channel;
    logic signed [CH_W-1:0] channel_3;
    logic signed [CH_W-1:0] channel_2;
    logic signed [CH_W-1:0] channel_1;
    logic signed [CH_W-1:0] channel_0;
  } decoded_t;

endpackage

/* design/rc_receiver_frame_decoder.sv */
// remote-control receiver frame decoder: byte collection, frame decode, link timeout
//
//  channel  | direction | handshake          | payload
//  s_*      | in        | s_tvalid/s_tready  | tuser: op; tdata: byte_value
//  m_*      | out       | m_tvalid/m_tready  | tdata: decoded fields and link_state
//  cfg_*    | in        | cfg_we             | cfg_index, cfg_data
//
// one word is taken per cycle while s_tready is high; frame decode, limit check
// and timeout compare all sit between the accepted word and the result register.
// an end of frame or a tick gives one result word in the next cycle.
// s_tready is low only while a result is held and m_tready is low.
// reset (rst, synchronous) clears count, timer, status and decoded values.
module rc_receiver_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [rcfd_pkg::IN_DATA_W-1:0]     s_tdata,   // byte_value
  input  logic [rcfd_pkg::IN_USER_W-1:0]     s_tuser,   // op
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // channel_0, channel_1, channel_2, channel_3, dial_channel, switches,
  // mouse_x, mouse_y, mouse_z, mouse_buttons, key_mask, link_state, zero fill
  output logic [rcfd_pkg::OUT_DATA_W-1:0]    m_tdata,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [rcfd_pkg::CFG_W-1:0]         cfg_data
);
  import rcfd_pkg::*;

  logic [7:0]         frame_bytes [FRAME_LENGTH];
  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]        elapsed_ms, elapsed_ms_next;
  link_t              link_status, link_status_next;
  decoded_t           decoded, decoded_next;
  logic [15:0]        offline_timeout_ms;
  logic [CH_W-1:0]    channel_error_limit;

  logic               s_accept;
  op_t                op_in;
  logic               emit;
  logic               buf_we;
  logic [CH_W-1:0]    raw [5];
  logic [CH_W-1:0]    chan [5];
  logic [CH_W:0]      mag [5];
  logic [4:0]         over;
  logic [1:0]         sw0, sw1;
  logic               frame_bad;
  decoded_t           frame_vals;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign op_in    = op_t'(s_tuser);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      offline_timeout_ms  <= TIMEOUT_RESET;
      channel_error_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIMEOUT: offline_timeout_ms  <= cfg_data;
        CFG_LIMIT:   channel_error_limit <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // fixed bit positions of the frame
  always_comb begin
    raw[0] = {frame_bytes[1][2:0], frame_bytes[0]};
    raw[1] = {frame_bytes[2][5:0], frame_bytes[1][7:3]};
    raw[2] = {frame_bytes[4][0], frame_bytes[3], frame_bytes[2][7:6]};
    raw[3] = {frame_bytes[5][3:0], frame_bytes[4][7:1]};
    raw[4] = {frame_bytes[17][2:0], frame_bytes[16]};
    for (int i = 0; i < 5; i++) begin
      // raw minus the 1024 offset
      chan[i] = {~raw[i][CH_W-1], raw[i][CH_W-2:0]};
      mag[i]  = raw[i][CH_W-1] ? {2'b00, raw[i][CH_W-2:0]}
                               : (12'd1024 - {2'b00, raw[i][CH_W-2:0]});
    end
    // a dial at full negative reads as centre
    if (raw[4] == '0) begin
      chan[4] = '0;
      mag[4]  = '0;
    end
    for (int i = 0; i < 5; i++) begin
      over[i] = mag[i] > {1'b0, channel_error_limit};
    end
    sw0       = frame_bytes[5][7:6];
    sw1       = frame_bytes[5][5:4];
    frame_bad = (|over) || (sw0 == 2'b00) || (sw1 == 2'b00);

    frame_vals.channel_0     = chan[0];
    frame_vals.channel_1     = chan[1];
    frame_vals.channel_2     = chan[2];
    frame_vals.channel_3     = chan[3];
    frame_vals.dial_channel  = chan[4];
    frame_vals.switches      = {sw0, sw1};
    frame_vals.mouse_x       = {frame_bytes[7], frame_bytes[6]};
    frame_vals.mouse_y       = {frame_bytes[9], frame_bytes[8]};
    frame_vals.mouse_z       = {frame_bytes[11], frame_bytes[10]};
    frame_vals.mouse_buttons = {frame_bytes[13], frame_bytes[12]};
    frame_vals.key_mask      = {frame_bytes[15], frame_bytes[14]};
  end

  // state update for one accepted word
  always_comb begin
    byte_count_next  = byte_count;
    elapsed_ms_next  = elapsed_ms;
    link_status_next = link_status;
    decoded_next     = decoded;
    emit             = 1'b0;
    buf_we           = 1'b0;
    if (s_accept) begin
      case (op_in)
        OP_BYTE: begin
          buf_we = byte_count < COUNT_FRAME;
          if (byte_count != COUNT_MAX) begin
            byte_count_next = byte_count + 1'b1;
          end
        end
        OP_EOF: begin
          if (byte_count == COUNT_FRAME) begin
            elapsed_ms_next = '0;
            if (frame_bad) begin
              link_status_next = LINK_ERROR;
              decoded_next     = '0;
            end else begin
              link_status_next = LINK_CONNECTED;
              decoded_next     = frame_vals;
            end
          end
          byte_count_next = '0;
          emit            = 1'b1;
        end
        OP_TICK: begin
          if (elapsed_ms != ELAPSED_MAX) begin
            elapsed_ms_next = elapsed_ms + 1'b1;
          end
          emit = 1'b1;
        end
        default: ;
      endcase
      if (elapsed_ms_next > offline_timeout_ms) begin
        link_status_next = LINK_LOST;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (buf_we) begin
      frame_bytes[byte_count] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      elapsed_ms  <= '0;
      link_status <= LINK_PENDING;
      decoded     <= '0;
    end else begin
      byte_count  <= byte_count_next;
      elapsed_ms  <= elapsed_ms_next;
      link_status <= link_status_next;
      decoded     <= decoded_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {3'b000, link_status_next, decoded_next};
    end
  end

  a_error_clears : assert property (@(posedge clk) disable iff (rst)
    link_status == LINK_ERROR |-> decoded == '0)
    else $error("error status with non-zero decoded values");

  a_eof_restarts : assert property (@(posedge clk) disable iff (rst)
    s_accept && op_in == OP_EOF |=> byte_count == '0)
    else $error("byte count not restarted after end of frame");

  a_result_follows : assert property (@(posedge clk) disable iff (rst)
    s_accept && (op_in == OP_EOF || op_in == OP_TICK) |=> m_tvalid)
    else $error("no result after end of frame or tick");

  a_timer_saturates : assert property (@(posedge clk) disable iff (rst)
    s_accept && op_in == OP_TICK && elapsed_ms == ELAPSED_MAX |=> elapsed_ms == ELAPSED_MAX)
    else $error("millisecond timer wrapped");

endmodule

/* tb/rcfd_checker.sv */
`timescale 1ns / 100ps
// frame decoder checker: watches the stream and config ports, predicts and compares results
module rcfd_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [rcfd_pkg::IN_DATA_W-1:0]  s_tdata,   // byte_value
  input  logic [rcfd_pkg::IN_USER_W-1:0]  s_tuser,   // op
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // channel_0..channel_3, dial_channel, switches, mouse_x, mouse_y, mouse_z,
  // mouse_buttons, key_mask, link_state, zero fill
  input  logic [rcfd_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [rcfd_pkg::CFG_W-1:0]      cfg_data,
  output int unsigned                     mismatches,
  output int unsigned                     outstanding
);
  import rcfd_pkg::*;

  localparam int FIELD_COUNT = 12;
  localparam int REPORT_W    = 141;

  // same layout as the low bits of m_tdata
  typedef struct packed {
    link_t    link;
    decoded_t vals;
  } report_t;

  logic [7:0]   frame_buf [FRAME_LENGTH];
  logic [4:0]   byte_cnt;
  logic [15:0]  ms_since_frame;
  link_t        link_now;
  decoded_t     held;
  logic [15:0]  timeout_cfg;
  logic [10:0]  limit_cfg;
  report_t      due_reports [$];

  function automatic void field_info(input int idx, output string name, output int width);
    case (idx)
      0: begin name = "channel_0"; width = 11; end
      1: begin name = "channel_1"; width = 11; end
      2: begin name = "channel_2"; width = 11; end
      3: begin name = "channel_3"; width = 11; end
      4: begin name = "dial_channel"; width = 11; end
      5: begin name = "switches"; width = 4; end
      6: begin name = "mouse_x"; width = 16; end
      7: begin name = "mouse_y"; width = 16; end
      8: begin name = "mouse_z"; width = 16; end
      9: begin name = "mouse_buttons"; width = 16; end
      10: begin name = "key_mask"; width = 16; end
      default: begin name = "link_state"; width = 2; end
    endcase
  endfunction

  task automatic decode_frame();
    logic [143:0] f;
    logic [10:0]  raw [5];
    int           v [5];
    int           mag;
    logic [1:0]   sw_a;
    logic [1:0]   sw_b;
    bit           bad;
    int           i;
    for (i = 0; i < FRAME_LENGTH; i++) f[8*i +: 8] = frame_buf[i];
    raw[0] = f[10:0];
    raw[1] = f[21:11];
    raw[2] = f[32:22];
    raw[3] = f[43:33];
    raw[4] = f[138:128];
    sw_a = f[47:46];
    sw_b = f[45:44];
    bad = (sw_a == 2'd0) || (sw_b == 2'd0);
    for (i = 0; i < 5; i++) begin
      v[i] = int'(raw[i]) - 1024;
      // dial at full negative travel reads as centre
      if (i == 4 && v[i] == -1024) v[i] = 0;
      mag = (v[i] < 0) ? -v[i] : v[i];
      if (mag > int'(limit_cfg)) bad = 1'b1;
    end
    if (bad) begin
      link_now = LINK_ERROR;
      held = '0;
    end else begin
      held.channel_0     = 11'(v[0]);
      held.channel_1     = 11'(v[1]);
      held.channel_2     = 11'(v[2]);
      held.channel_3     = 11'(v[3]);
      held.dial_channel  = 11'(v[4]);
      held.switches      = {sw_a, sw_b};
      held.mouse_x       = f[63:48];
      held.mouse_y       = f[79:64];
      held.mouse_z       = f[95:80];
      held.mouse_buttons = f[111:96];
      held.key_mask      = f[127:112];
      link_now = LINK_CONNECTED;
    end
  endtask

  task automatic take_word(input logic [1:0] op, input logic [7:0] b);
    report_t r;
    bit      reply;
    reply = 1'b0;
    case (op)
      OP_BYTE: begin
        if (byte_cnt < COUNT_FRAME) frame_buf[byte_cnt] = b;
        if (byte_cnt != COUNT_MAX) byte_cnt = byte_cnt + 5'd1;
      end
      OP_EOF: begin
        if (byte_cnt == COUNT_FRAME) begin
          ms_since_frame = '0;
          decode_frame();
        end
        byte_cnt = '0;
        reply = 1'b1;
      end
      OP_TICK: begin
        if (ms_since_frame != ELAPSED_MAX) ms_since_frame = ms_since_frame + 16'd1;
        reply = 1'b1;
      end
      default: ;
    endcase
    // timeout is checked after every word, whatever the op
    if (ms_since_frame > timeout_cfg) link_now = LINK_LOST;
    if (reply) begin
      r.link = link_now;
      r.vals = held;
      due_reports.push_back(r);
    end
  endtask

  task automatic check_report(input logic [OUT_DATA_W-1:0] word);
    report_t              want;
    logic [REPORT_W-1:0]  got;
    logic [REPORT_W-1:0]  mask;
    logic [REPORT_W-1:0]  e;
    logic [REPORT_W-1:0]  a;
    string                name;
    int                   width;
    int                   lsb;
    int                   i;
    if (due_reports.size() == 0) begin
      if (mismatches < 10) $display("unexpected result word %h", word);
      mismatches++;
      return;
    end
    want = due_reports.pop_front();
    got = word[REPORT_W-1:0];
    lsb = 0;
    for (i = 0; i < FIELD_COUNT; i++) begin
      field_info(i, name, width);
      mask = (REPORT_W'(1) << width) - REPORT_W'(1);
      e = (want >> lsb) & mask;
      a = (got >> lsb) & mask;
      if (a !== e) begin
        if (mismatches < 10)
          $display("%s mismatch: expected %h, got %h", name, e, a);
        mismatches++;
      end
      lsb = lsb + width;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_cnt       = '0;
      ms_since_frame = '0;
      link_now       = LINK_PENDING;
      held           = '0;
      timeout_cfg    = TIMEOUT_RESET;
      limit_cfg      = LIMIT_RESET;
      mismatches     = 0;
      due_reports.delete();
    end else begin
      // results leave before this edge's word is predicted
      if (m_tvalid && m_tready) check_report(m_tdata);
      if (cfg_we) begin
        if (cfg_index == CFG_TIMEOUT) timeout_cfg = cfg_data;
        else limit_cfg = cfg_data[10:0];
      end
      if (s_tvalid && s_tready) take_word(s_tuser, s_tdata);
    end
    outstanding = due_reports.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// frame decoder testbench top: clock, reset, stimulus, idling phases and verdict
module testbench;
  import rcfd_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned IDLE_LIMIT  = 20000;
  localparam int unsigned PHASE_WORDS = 220;
  localparam int unsigned PHASES      = 8;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = CFG_TIMEOUT;
  logic [CFG_W-1:0]      cfg_data = '0;
  int unsigned           mismatches;
  int unsigned           outstanding;

  int unsigned src_idle = 0;
  int unsigned sink_stall = 0;
  int unsigned words_sent = 0;
  int unsigned quiet = 0;
  int unsigned cur_timeout = TIMEOUT_RESET;
  int unsigned cur_limit = LIMIT_RESET;
  int unsigned timeout_tbl [PHASES] = '{5, 0, 2, 1000, 1, 65535, 40, 100};
  int unsigned limit_tbl [PHASES] = '{700, 0, 1024, 2047, 1, 350, 1023, 500};

  rc_receiver_frame_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcfd_checker chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_stall);

  // ends the run when no word moves on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == IDLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op != OP_UNUSED) words_sent++;
  endtask

  task automatic send_tick();
    send_word(OP_TICK, 8'($urandom_range(255)));
  endtask

  // len bytes then end of frame; bytes past the frame length are noise
  task automatic send_frame(input logic [143:0] f, input int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) send_tick();
      send_word(OP_BYTE, (i < FRAME_LENGTH) ? f[8*i +: 8] : 8'($urandom_range(255)));
    end
    send_word(OP_EOF, 8'($urandom_range(255)));
  endtask

  function automatic logic [143:0] make_frame(input bit corrupt);
    logic [159:0] noise;
    logic [143:0] f;
    logic [10:0]  raw [5];
    logic [2:0]   k;
    int           span;
    int           v;
    int           i;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    f = noise[143:0];
    span = (cur_limit > 1023) ? 1023 : int'(cur_limit);
    for (i = 0; i < 5; i++) begin
      case ($urandom_range(5))
        0: v = span;
        1: v = -span;
        2: v = int'($urandom_range(2047)) - 1024;
        default: v = int'($urandom_range(2 * span)) - span;
      endcase
      raw[i] = 11'(v + 1024);
    end
    if ($urandom_range(9) == 0) raw[4] = '0;
    f[47:46] = 2'($urandom_range(1, 3));
    f[45:44] = 2'($urandom_range(1, 3));
    if (corrupt) begin
      k = 3'($urandom_range(4));
      if ($urandom_range(1) == 1) raw[k] = 11'($urandom);
      else if ($urandom_range(1) == 1) f[47:46] = 2'd0;
      else f[45:44] = 2'd0;
    end
    f[10:0]    = raw[0];
    f[21:11]   = raw[1];
    f[32:22]   = raw[2];
    f[43:33]   = raw[3];
    f[138:128] = raw[4];
    return f;
  endfunction

  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // bytes give no result, so allow the pipeline to drain
    repeat (3) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned timeout_ms, input int unsigned limit);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TIMEOUT;
    cfg_data  <= 16'(timeout_ms);
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_data  <= 16'(limit);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_timeout = timeout_ms;
    cur_limit = limit;
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned target;
    int unsigned pick;
    int unsigned n;
    int unsigned len;
    target = words_sent + quota;
    while (words_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        send_frame(make_frame(1'b0), FRAME_LENGTH);
      end else if (pick < 65) begin
        send_frame(make_frame(1'b1), FRAME_LENGTH);
      end else if (pick < 75) begin
        len = $urandom_range(40);
        if (len == FRAME_LENGTH) len = 0;
        send_frame(make_frame(1'b0), len);
      end else if (pick < 92) begin
        // sometimes run the timer just past a short timeout
        if ($urandom_range(5) == 0 && cur_timeout <= 200) n = cur_timeout + 2;
        else n = $urandom_range(1, 5);
        repeat (n) send_tick();
      end else if (pick < 96) begin
        send_word(OP_UNUSED, 8'($urandom_range(255)));
      end else begin
        send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    logic [143:0] f;
    int unsigned  phase;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: empty traffic, unused op, short frame, then a frame at the limits
    send_tick();
    send_word(OP_EOF, 8'hFF);
    send_word(OP_UNUSED, 8'h00);
    f = make_frame(1'b0);
    send_frame(f, 2);
    f[10:0]     = 11'd1024 + LIMIT_RESET;
    f[21:11]    = 11'd1024 - LIMIT_RESET;
    f[32:22]    = 11'd1024 + LIMIT_RESET;
    f[43:33]    = 11'd1024 - LIMIT_RESET;
    f[47:44]    = 4'hF;
    f[63:48]    = 16'h8000;
    f[79:64]    = 16'h7FFF;
    f[95:80]    = 16'hFFFF;
    f[111:96]   = 16'hFFFF;
    f[127:112]  = 16'h0000;
    f[138:128]  = 11'd0;
    send_frame(f, FRAME_LENGTH);

    timeout_tbl[PHASES-1] = $urandom_range(1, 65535);
    limit_tbl[PHASES-1] = $urandom_range(1024);
    for (phase = 0; phase < PHASES; phase++) begin
      settle();
      set_config(timeout_tbl[phase], limit_tbl[phase]);
      case (phase % 4)
        0: begin src_idle = 0; sink_stall = 0; end
        1: begin src_idle = 79; sink_stall = 0; end
        2: begin src_idle = 0; sink_stall = 79; end
        default: begin src_idle = 11; sink_stall = 11; end
      endcase
      run_random(PHASE_WORDS);
    end

    src_idle = 0;
    sink_stall = 0;
    settle();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
